FILE: src/dia_pkg.sv
// Shared types, field widths, codes and reset values of the descriptor index allocator.
package dia_pkg;

    localparam int IDX_W     = 10;
    localparam int LIMIT_W   = 11;
    localparam int STRIDE_W  = 13;
    localparam int ADDR_W    = 64;
    localparam int STATUS_W  = 3;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_VAL_W = 64;

    localparam int MAX_SLOTS_DEFAULT = 1024;

    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_STRIDE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENABLED  = 3'd5;

    localparam logic [LIMIT_W-1:0]  SLOT_LIMIT_RESET = 11'd1024;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET     = 13'd32;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [IDX_W-1:0]    slot;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]    granted_slot;
        logic [STATUS_W-1:0] status;
        logic                can_allocate;
        logic                slot_in_use;
        logic [IDX_W-1:0]    live_count;
        logic [ADDR_W-1:0]   cpu_address;
        logic [ADDR_W-1:0]   gpu_address;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic decide;
        logic load;
        logic clear_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic table_write;
        logic clear_last;
    } ctrl_status_t;

endpackage

FILE: src/dia_chan_if.sv
// Valid/ready channel interface carrying one payload of a given type.
interface dia_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/descriptor_index_allocator_core.sv
// A result is formed in the decide cycle and loaded with its addresses in the address cycle, which
// waits while the output holds an unaccepted result. The mark and stack memories are read in the
// transfer cycle and written back in the decide cycle, and the next transfer overlaps the address cycle.
// Reset and every write of table_enabled start a clearing pass over every entry of the
// used-mark memory; no request is taken during it, configuration writes still are.
module descriptor_index_allocator_core #(
    parameter int MAX_SLOTS = dia_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    dia_chan_if.sink   cfg,
    dia_chan_if.sink   req,
    dia_chan_if.source rsp
);

    dia_pkg::ctrl_cmd_t    cmd;
    dia_pkg::ctrl_status_t status;
    dia_pkg::rsp_t         rsp_data;
    logic                  req_ready;
    logic                  rsp_valid;

    dia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .cmd       (cmd)
    );

    dia_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req_data (req.data),
        .cmd      (cmd),
        .status   (status),
        .rsp_data (rsp_data)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

endmodule

FILE: src/dia_ctrl.sv
// Sequencing state machine of the descriptor index allocator.
module dia_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  rsp_ready,
    input  dia_pkg::ctrl_status_t status,
    output logic                  req_ready,
    output logic                  rsp_valid,
    output dia_pkg::ctrl_cmd_t    cmd
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_ADDR   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    always_comb
    begin
        out_free       = !rsp_valid_reg || rsp_ready;
        req_ready      = (state_reg == S_IDLE) || ((state_reg == S_ADDR) && out_free);
        cmd.accept     = req_valid && req_ready;
        cmd.decide     = (state_reg == S_DECIDE);
        cmd.load       = (state_reg == S_ADDR) && out_free;
        cmd.clear_step = (state_reg == S_CLEAR);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                // A new request may be taken in the same cycle the result is loaded.
                if (out_free)
                begin
                    state_next = cmd.accept ? S_DECIDE : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        if (status.table_write)
        begin
            state_next = S_CLEAR;
        end
    end

    always_comb
    begin
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    a_accept_then_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !status.table_write) |=> cmd.decide)
        else $error("accepted request was not followed by a decide cycle");

    a_decide_then_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && !status.table_write) |=> (state_reg == S_ADDR))
        else $error("decide cycle was not followed by the address cycle");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> rsp_valid_reg)
        else $error("loaded result is not presented");

endmodule

FILE: src/dia_datapath.sv
// Configuration registers, free stack, used-mark memory and result datapath.
module dia_datapath #(
    parameter int MAX_SLOTS = dia_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dia_chan_if.sink              cfg,
    input  dia_pkg::req_t         req_data,
    input  dia_pkg::ctrl_cmd_t    cmd,
    output dia_pkg::ctrl_status_t status,
    output dia_pkg::rsp_t         rsp_data
);

    localparam int IDX_W     = dia_pkg::IDX_W;
    localparam int LIMIT_W   = dia_pkg::LIMIT_W;
    localparam int STRIDE_W  = dia_pkg::STRIDE_W;
    localparam int ADDR_W    = dia_pkg::ADDR_W;
    localparam int STATUS_W  = dia_pkg::STATUS_W;
    localparam int ACTION_W  = dia_pkg::ACTION_W;
    localparam int PROD_W    = STRIDE_W + LIMIT_W;
    localparam int MARK_AW   = $clog2(MAX_SLOTS);
    localparam int STK_DEPTH = MAX_SLOTS - 1;
    localparam int STK_AW    = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
    localparam int DEPTH_W   = $clog2(MAX_SLOTS);
    localparam int MAXW      = $clog2(MAX_SLOTS + 1);
    localparam int CW        = (MAXW > LIMIT_W) ? MAXW : LIMIT_W;
    localparam logic [CW-1:0]      MAX_C     = CW'(MAX_SLOTS);
    localparam logic [MARK_AW-1:0] CLR_LAST  = MARK_AW'(MAX_SLOTS - 1);

    // Configuration registers.
    logic [LIMIT_W-1:0]  slot_limit_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;
    logic                shader_visible_reg;
    logic                enabled_reg;
    logic                cfg_write;

    // Allocation state.
    logic [DEPTH_W-1:0]  depth_reg;
    logic [DEPTH_W-1:0]  depth_next;
    logic [LIMIT_W-1:0]  bump_reg;
    logic [LIMIT_W-1:0]  bump_next;
    logic [LIMIT_W-1:0]  count_reg;
    logic [LIMIT_W-1:0]  count_next;
    logic [MARK_AW-1:0]  clr_cnt_reg;
    logic [MARK_AW-1:0]  clr_cnt_next;

    logic [IDX_W-1:0]    free_stack_reg [STK_DEPTH];
    logic                used_marks_reg [MAX_SLOTS];

    // Request latched at the transfer and the memory read data for it.
    logic [ACTION_W-1:0] act_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    stk_rd_reg;
    logic                mark_rd_reg;

    // Result held between the decide and address cycles.
    logic [IDX_W-1:0]    res_granted_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_can_reg;
    logic                res_inuse_reg;
    logic [IDX_W-1:0]    res_count_reg;
    logic [PROD_W-1:0]   prod_reg;
    dia_pkg::rsp_t       rsp_reg;

    logic [CW-1:0]       req_slot_wide;
    logic [CW-1:0]       slot_wide;
    logic [CW-1:0]       mark_wa_wide;
    logic [DEPTH_W-1:0]  depth_m1;
    logic [LIMIT_W-1:0]  lim;
    logic [LIMIT_W-1:0]  slot_l;
    logic                slot_marked;

    logic [LIMIT_W-1:0]  granted_c;
    logic [LIMIT_W-1:0]  rel_c;
    logic [STATUS_W-1:0] status_c;
    logic                inuse_c;
    logic                can_c;
    logic                mark_set_c;
    logic                push_c;
    logic [DEPTH_W-1:0]  depth_dec;
    logic [LIMIT_W-1:0]  bump_dec;
    logic [LIMIT_W-1:0]  count_dec;
    logic [PROD_W-1:0]   prod_c;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign status.table_write = cfg_write && (cfg.data.index == dia_pkg::REG_TABLE_ENABLED);
    assign status.clear_last  = (clr_cnt_reg == CLR_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg     <= dia_pkg::SLOT_LIMIT_RESET;
            stride_reg         <= dia_pkg::STRIDE_RESET;
            cpu_base_reg       <= '0;
            gpu_base_reg       <= '0;
            shader_visible_reg <= 1'b0;
            enabled_reg        <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg.data.index)
                dia_pkg::REG_SLOT_LIMIT:     slot_limit_reg     <= cfg.data.value[LIMIT_W-1:0];
                dia_pkg::REG_ENTRY_STRIDE:   stride_reg         <= cfg.data.value[STRIDE_W-1:0];
                dia_pkg::REG_CPU_BASE:       cpu_base_reg       <= cfg.data.value;
                dia_pkg::REG_GPU_BASE:       gpu_base_reg       <= cfg.data.value;
                dia_pkg::REG_SHADER_VISIBLE: shader_visible_reg <= cfg.data.value[0];
                dia_pkg::REG_TABLE_ENABLED:  enabled_reg        <= cfg.data.value[0];
                default:
                begin
                end
            endcase
        end
    end

    // Memory reads are issued at the request transfer.
    assign req_slot_wide = CW'(req_data.slot);
    assign depth_m1      = depth_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg     <= req_data.action;
            slot_reg    <= req_data.slot;
            mark_rd_reg <= used_marks_reg[req_slot_wide[MARK_AW-1:0]];
            if (depth_reg != '0)
            begin
                stk_rd_reg <= free_stack_reg[depth_m1[STK_AW-1:0]];
            end
        end
    end

    always_comb
    begin
        if (!enabled_reg)
        begin
            lim = '0;
        end
        else if (CW'(slot_limit_reg) > MAX_C)
        begin
            lim = MAX_C[LIMIT_W-1:0];
        end
        else
        begin
            lim = slot_limit_reg;
        end
    end

    assign slot_wide   = CW'(slot_reg);
    assign slot_l      = LIMIT_W'(slot_reg);
    // Slots beyond the mark memory alias on the read address and count as unmarked.
    assign slot_marked = (slot_wide < MAX_C) && mark_rd_reg;

    always_comb
    begin
        granted_c  = '0;
        rel_c      = slot_l;
        status_c   = dia_pkg::ST_OK;
        inuse_c    = slot_marked;
        mark_set_c = 1'b0;
        push_c     = 1'b0;
        depth_dec  = depth_reg;
        bump_dec   = bump_reg;
        count_dec  = count_reg;
        case (act_reg)
            dia_pkg::ACT_ALLOC:
            begin
                rel_c   = '0;
                inuse_c = 1'b0;
                if (enabled_reg && (depth_reg != '0))
                begin
                    granted_c  = LIMIT_W'(stk_rd_reg);
                    depth_dec  = depth_m1;
                    mark_set_c = 1'b1;
                end
                else if (enabled_reg && (bump_reg < lim))
                begin
                    granted_c  = bump_reg;
                    bump_dec   = bump_reg + 1'b1;
                    mark_set_c = 1'b1;
                end
                else
                begin
                    status_c = dia_pkg::ST_EXHAUSTED;
                end
                if (mark_set_c)
                begin
                    count_dec = count_reg + 1'b1;
                    rel_c     = granted_c;
                    inuse_c   = 1'b1;
                end
            end
            dia_pkg::ACT_FREE:
            begin
                if ((slot_reg == '0) || !enabled_reg)
                begin
                    status_c = dia_pkg::ST_IGNORED;
                end
                else if (slot_l >= lim)
                begin
                    status_c = dia_pkg::ST_RANGE;
                end
                else if (!mark_rd_reg)
                begin
                    status_c = dia_pkg::ST_NOT_ALLOC;
                end
                else
                begin
                    push_c    = 1'b1;
                    inuse_c   = 1'b0;
                    depth_dec = depth_reg + 1'b1;
                    count_dec = count_reg - 1'b1;
                end
            end
            dia_pkg::ACT_QUERY:
            begin
                status_c = (slot_l >= lim) ? dia_pkg::ST_RANGE : dia_pkg::ST_OK;
            end
            default:
            begin
                status_c = dia_pkg::ST_IGNORED;
            end
        endcase
        can_c = enabled_reg && ((depth_dec != '0) || (bump_dec < lim));
    end

    assign prod_c = PROD_W'(stride_reg) * PROD_W'(rel_c);

    always_comb
    begin
        depth_next   = depth_reg;
        bump_next    = bump_reg;
        count_next   = count_reg;
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear_step)
        begin
            clr_cnt_next = status.clear_last ? '0 : clr_cnt_reg + 1'b1;
        end
        if (cmd.decide)
        begin
            depth_next = depth_dec;
            bump_next  = bump_dec;
            count_next = count_dec;
        end
        // Any write of the enable register restarts allocation from scratch.
        if (status.table_write)
        begin
            depth_next   = '0;
            bump_next    = LIMIT_W'(1);
            count_next   = '0;
            clr_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            bump_reg    <= LIMIT_W'(1);
            count_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            depth_reg   <= depth_next;
            bump_reg    <= bump_next;
            count_reg   <= count_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign mark_wa_wide = mark_set_c ? CW'(granted_c) : slot_wide;

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            used_marks_reg[clr_cnt_reg] <= 1'b0;
        end
        else if (cmd.decide && (mark_set_c || push_c))
        begin
            used_marks_reg[mark_wa_wide[MARK_AW-1:0]] <= mark_set_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide && push_c)
        begin
            free_stack_reg[depth_reg[STK_AW-1:0]] <= slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            res_granted_reg <= granted_c[IDX_W-1:0];
            res_status_reg  <= status_c;
            res_can_reg     <= can_c;
            res_inuse_reg   <= inuse_c;
            res_count_reg   <= count_dec[IDX_W-1:0];
            prod_reg        <= prod_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_reg.granted_slot <= res_granted_reg;
            rsp_reg.status       <= res_status_reg;
            rsp_reg.can_allocate <= res_can_reg;
            rsp_reg.slot_in_use  <= res_inuse_reg;
            rsp_reg.live_count   <= res_count_reg;
            rsp_reg.cpu_address  <= cpu_base_reg + ADDR_W'(prod_reg);
            rsp_reg.gpu_address  <= shader_visible_reg ? gpu_base_reg + ADDR_W'(prod_reg) : '0;
        end
    end

    assign rsp_data = rsp_reg;

    // Every slot handed out by the bump pointer is either live or waiting on the stack.
    a_slot_conservation: assert property (@(posedge clk) disable iff (!rst_n)
        ((CW + 1)'(bump_reg) == (CW + 1)'(count_reg) + (CW + 1)'(depth_reg) + (CW + 1)'(1)))
        else $error("bump pointer, live count and stack depth disagree");

    a_enable_clears: assert property (@(posedge clk) disable iff (!rst_n)
        status.table_write |=> ((depth_reg == '0) && (count_reg == '0)))
        else $error("enable write did not clear the allocation state");

    a_no_decide_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.decide && cmd.clear_step))
        else $error("request decided while the mark memory is being cleared");

endmodule

FILE: dv/tb_descriptor_index_allocator_core.sv
// Testbench of the descriptor index allocator: directed and random requests with a predictor.
module tb_descriptor_index_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dia_pkg::*;

    // The block answers any action code outside the defined three as ignored.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    dia_chan_if #(.T(cfg_t)) cfg_ch ();
    dia_chan_if #(.T(req_t)) req_ch ();
    dia_chan_if #(.T(rsp_t)) rsp_ch ();

    descriptor_index_allocator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    req_t queued_requests[$];
    rsp_t awaited_responses[$];
    rsp_t want_rsp;
    bit   offer;
    bit   calm;
    bit   holding;
    int   send_idle;
    int   recv_idle;
    int   results_seen;
    int   error_count;

    // Shadow copy of the configuration registers.
    logic [LIMIT_W-1:0]  slot_limit_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;
    logic                visible_reg;
    logic                tbl_enabled;

    // Shadow allocation state.
    logic [IDX_W-1:0] free_stack [MAX_SLOTS_DEFAULT];
    bit               used_marks [MAX_SLOTS_DEFAULT];
    int               stack_depth;
    int               bump_next;
    int               live_total;

    function automatic void clear_slot_state();
        foreach (used_marks[i])
            used_marks[i] = 1'b0;
        stack_depth = 0;
        bump_next   = 1;
        live_total  = 0;
    endfunction

    function automatic int usable_limit();
        if (!tbl_enabled)
            return 0;
        return (slot_limit_reg > MAX_SLOTS_DEFAULT) ? MAX_SLOTS_DEFAULT : int'(slot_limit_reg);
    endfunction

    function automatic rsp_t compute_slot_response(req_t r);
        rsp_t                resp;
        int                  lim;
        logic [IDX_W-1:0]    rel;
        logic [IDX_W-1:0]    granted;
        logic [STATUS_W-1:0] st;
        lim     = usable_limit();
        rel     = r.slot;
        granted = '0;
        st      = ST_OK;
        case (r.action)
            ACT_ALLOC:
            begin
                rel = '0;
                if (tbl_enabled && stack_depth > 0)
                begin
                    stack_depth--;
                    granted = free_stack[stack_depth];
                end
                else if (tbl_enabled && bump_next < lim)
                begin
                    granted = IDX_W'(bump_next);
                    bump_next++;
                end
                else
                    st = ST_EXHAUSTED;
                if (st == ST_OK)
                begin
                    used_marks[granted] = 1'b1;
                    live_total++;
                    rel = granted;
                end
            end
            ACT_FREE:
            begin
                if (r.slot == 0 || !tbl_enabled)
                    st = ST_IGNORED;
                else if (r.slot >= lim)
                    st = ST_RANGE;
                else if (!used_marks[r.slot])
                    st = ST_NOT_ALLOC;
                else
                begin
                    used_marks[r.slot] = 1'b0;
                    live_total--;
                    free_stack[stack_depth] = r.slot;
                    stack_depth++;
                end
            end
            ACT_QUERY:
                st = (r.slot >= lim) ? ST_RANGE : ST_OK;
            default:
                st = ST_IGNORED;
        endcase
        resp.granted_slot = granted;
        resp.status       = st;
        resp.can_allocate = tbl_enabled && (stack_depth > 0 || bump_next < lim);
        resp.slot_in_use  = used_marks[rel];
        resp.live_count   = IDX_W'(live_total);
        resp.cpu_address  = cpu_base_reg + ADDR_W'(stride_reg) * ADDR_W'(rel);
        resp.gpu_address  = visible_reg ? gpu_base_reg + ADDR_W'(stride_reg) * ADDR_W'(rel) : '0;
        return resp;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Sender: presents the oldest queued request and predicts its result on transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            send_idle = 0;
        end
        else
        begin
            offer = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                awaited_responses.push_back(compute_slot_response(req_ch.data));
                void'(queued_requests.pop_front());
                offer = 1'b0;
            end
            if (!offer && queued_requests.size() > 0)
            begin
                if (send_idle > 0)
                    send_idle--;
                else if (!calm && $urandom_range(0, 5) == 0)
                    send_idle = $urandom_range(0, 2);
                else
                    offer = 1'b1;
            end
            req_ch.valid <= offer;
            if (offer)
                req_ch.data <= queued_requests[0];
        end
    end

    // Receiver: checks every result transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_idle = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (awaited_responses.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want_rsp = awaited_responses.pop_front();
                    if (rsp_ch.data.granted_slot !== want_rsp.granted_slot)
                        report_mismatch($sformatf("granted_slot got %0d want %0d",
                            rsp_ch.data.granted_slot, want_rsp.granted_slot));
                    if (rsp_ch.data.status !== want_rsp.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                            rsp_ch.data.status, want_rsp.status));
                    if (rsp_ch.data.can_allocate !== want_rsp.can_allocate)
                        report_mismatch($sformatf("can_allocate got %0b want %0b",
                            rsp_ch.data.can_allocate, want_rsp.can_allocate));
                    if (rsp_ch.data.slot_in_use !== want_rsp.slot_in_use)
                        report_mismatch($sformatf("slot_in_use got %0b want %0b",
                            rsp_ch.data.slot_in_use, want_rsp.slot_in_use));
                    if (rsp_ch.data.live_count !== want_rsp.live_count)
                        report_mismatch($sformatf("live_count got %0d want %0d",
                            rsp_ch.data.live_count, want_rsp.live_count));
                    if (rsp_ch.data.cpu_address !== want_rsp.cpu_address)
                        report_mismatch($sformatf("cpu_address got %h want %h",
                            rsp_ch.data.cpu_address, want_rsp.cpu_address));
                    if (rsp_ch.data.gpu_address !== want_rsp.gpu_address)
                        report_mismatch($sformatf("gpu_address got %h want %h",
                            rsp_ch.data.gpu_address, want_rsp.gpu_address));
                end
            end
            if (recv_idle > 0)
            begin
                recv_idle--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                recv_idle = $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= !holding;
        end
    end

    function automatic void queue_item(logic [ACTION_W-1:0] action, int slot_no);
        req_t r;
        r.action = action;
        r.slot   = IDX_W'(slot_no);
        queued_requests.push_back(r);
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (queued_requests.size() != 0 || awaited_responses.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index_code, logic [CFG_VAL_W-1:0] value);
        cfg_t w;
        w.index = index_code;
        w.value = value;
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (index_code)
            REG_SLOT_LIMIT:     slot_limit_reg = value[LIMIT_W-1:0];
            REG_ENTRY_STRIDE:   stride_reg     = value[STRIDE_W-1:0];
            REG_CPU_BASE:       cpu_base_reg   = value;
            REG_GPU_BASE:       gpu_base_reg   = value;
            REG_SHADER_VISIBLE: visible_reg    = value[0];
            REG_TABLE_ENABLED:
            begin
                tbl_enabled = value[0];
                clear_slot_state();
            end
            default: ;
        endcase
    endtask

    // Mostly well-formed traffic: frees aim at slots that are likely handed out already.
    task automatic queue_random_items(int count, int alloc_pct);
        int lim;
        int allocs;
        int pick;
        int top;
        lim    = usable_limit();
        allocs = 0;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            top  = (lim - 1 < allocs + 2) ? lim - 1 : allocs + 2;
            if (top < 1)
                top = 1;
            if (pick < alloc_pct)
            begin
                queue_item(ACT_ALLOC, $urandom_range(0, 1023));
                allocs++;
            end
            else if (pick < alloc_pct + 32)
                queue_item(ACT_FREE, $urandom_range(1, top));
            else if (pick < alloc_pct + 42)
                queue_item(ACT_QUERY, $urandom_range(0, top));
            else if (pick < alloc_pct + 50)
                queue_item(ACT_FREE, $urandom_range(0, 1023));
            else if (pick < alloc_pct + 56)
                queue_item(ACT_QUERY, $urandom_range(0, 1023));
            else
                queue_item(ACT_UNUSED, $urandom_range(0, 1023));
        end
    endtask

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    // Long receiver hold-off while the sender keeps offering, so the block backs up.
    initial
    begin
        holding = 1'b0;
        @(negedge clk);
        while (results_seen < 200)
            @(negedge clk);
        @(posedge clk);
        holding <= 1'b1;
        repeat (300) @(posedge clk);
        holding <= 1'b0;
    end

    initial
    begin
        int lim_value;
        int count;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        calm         = 1'b0;
        error_count  = 0;
        results_seen = 0;
        slot_limit_reg = SLOT_LIMIT_RESET;
        stride_reg     = STRIDE_RESET;
        cpu_base_reg   = '0;
        gpu_base_reg   = '0;
        visible_reg    = 1'b0;
        tbl_enabled    = 1'b0;
        clear_slot_state();
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Table still disabled after reset.
        @(negedge clk);
        queue_item(ACT_ALLOC, 0);
        queue_item(ACT_FREE, 5);
        queue_item(ACT_QUERY, 0);
        wait_drained();

        // Small table whose upper addresses wrap around 2^64.
        write_reg(REG_SLOT_LIMIT, 8);
        write_reg(REG_ENTRY_STRIDE, 4096);
        write_reg(REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_GPU_BASE, 64'hFFFF_FFFF_FFFF_F000);
        write_reg(REG_SHADER_VISIBLE, 1);
        write_reg(REG_TABLE_ENABLED, 1);
        @(negedge clk);
        repeat (8) queue_item(ACT_ALLOC, 0);
        queue_item(ACT_FREE, 0);
        queue_item(ACT_FREE, 8);
        queue_item(ACT_FREE, 1023);
        queue_item(ACT_FREE, 3);
        queue_item(ACT_FREE, 3);
        queue_item(ACT_FREE, 5);
        queue_item(ACT_ALLOC, 0);
        queue_item(ACT_ALLOC, 0);
        queue_item(ACT_QUERY, 2);
        queue_item(ACT_QUERY, 1023);
        queue_item(ACT_UNUSED, 1023);
        queue_item(ACT_FREE, 6);
        wait_drained();

        // Lowering the limit keeps the freed slot on the stack available.
        write_reg(REG_SLOT_LIMIT, 4);
        @(negedge clk);
        queue_item(ACT_ALLOC, 0);
        queue_item(ACT_FREE, 6);
        queue_item(ACT_ALLOC, 0);

        for (int k = 0; k < 10; k++)
        begin
            wait_drained();
            case (k)
                0:       lim_value = 2;
                1:       lim_value = 2047;
                2:       lim_value = 1;
                4:       lim_value = 0;
                default: lim_value = $urandom_range(3, 64);
            endcase
            write_reg(REG_SLOT_LIMIT, lim_value);
            if (k == 0)
            begin
                write_reg(REG_ENTRY_STRIDE, 1);
                write_reg(REG_CPU_BASE, 0);
                write_reg(REG_GPU_BASE, 0);
            end
            else
            begin
                write_reg(REG_ENTRY_STRIDE, (k == 1) ? 4096 : $urandom_range(1, 4096));
                write_reg(REG_CPU_BASE, {$urandom, $urandom});
                write_reg(REG_GPU_BASE, {$urandom, $urandom});
            end
            write_reg(REG_SHADER_VISIBLE, $urandom_range(0, 1));
            // Even phases past the fourth keep the allocation state of the phase before.
            if (k == 3)
                write_reg(REG_TABLE_ENABLED, 0);
            else if (k < 5 || k % 2 == 1)
                write_reg(REG_TABLE_ENABLED, 1);
            if (k == 9)
                calm <= 1'b1;
            if (k == 0)
                count = 100;
            else if (k == 1)
                count = 250;
            else if (k < 5)
                count = 40;
            else
                count = 130;
            @(negedge clk);
            queue_random_items(count, (k == 1) ? 70 : 40);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
